// ===== hdl/sobel_pkg.sv =====
package sobel_pkg;

	// Pixel, row counter, register and configuration widths
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned ROW_W   = 12;
	localparam int unsigned WREG_W  = 11;
	localparam int unsigned HREG_W  = 13;
	localparam int unsigned CFG_DW  = 13;
	localparam int unsigned CFG_IW  = 2;
	// Signed width of one mask response (range -1020..1020)
	localparam int unsigned RESP_W  = 11;

	localparam logic [HREG_W-1:0] HEIGHT_LIMIT = 13'd4096;
	localparam logic [HREG_W-1:0] HEIGHT_MIN   = 13'd3;
	localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;

	typedef logic [CFG_IW-1:0] cfg_index_t;
	localparam cfg_index_t CFG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_index_t CFG_IMAGE_HEIGHT = 2'd1;
	localparam cfg_index_t CFG_EDGE_SELECT  = 2'd2;

	typedef enum logic [1:0] {
		SEL_VERT  = 2'd0,
		SEL_HORIZ = 2'd1,
		SEL_SUM   = 2'd2
	} edge_sel_t;

	typedef logic [PIX_W-1:0] pix_t;

endpackage

// ===== hdl/sobel_edge_3x3_top.sv =====
// Channel   Signals                              Direction  Moves
// input     in_valid, in_stall, pixel            in         one pixel per transfer
// output    out_valid, out_stall, magnitude,     out        one result per interior pixel
//           frame_last
// config    cfg_we, cfg_index, cfg_data          in         one register write per cycle
//
// One pixel per clock sustained while in_stall is low; a result passes stage 1, stage 2 and
// the output register after its input transfer. The line stores are read when a pixel is
// taken and written back when it leaves the first stage, so one read and one write port
// per store carry that pixel rate. Reset clears counters, window registers, stage valids
// and the output valid; the line stores and output data are not cleared. in_stall rises
// only while the output holds a stalled result and both inner stages are full.
module sobel_edge_3x3_top #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sobel_pkg::PIX_W-1:0]      pixel,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sobel_pkg::PIX_W-1:0]      magnitude,
	output logic                             frame_last,
	input  logic                             cfg_we,
	input  logic [sobel_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [sobel_pkg::CFG_DW-1:0]     cfg_data
);

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned CMPW = (CW + 1 > sobel_pkg::WREG_W + 1) ? CW + 1
	                                                               : sobel_pkg::WREG_W + 1;
	localparam int unsigned RW   = sobel_pkg::ROW_W;
	localparam int unsigned HW   = sobel_pkg::HREG_W;
	localparam int unsigned SW   = sobel_pkg::RESP_W;
	localparam int unsigned PW   = sobel_pkg::PIX_W;

	// Configuration registers
	logic [sobel_pkg::WREG_W-1:0] width_q;
	logic [HW-1:0]                height_q;
	sobel_pkg::edge_sel_t         sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobel_pkg::WIDTH_RESET;
			height_q <= sobel_pkg::HEIGHT_RESET;
			sel_q    <= sobel_pkg::SEL_SUM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sobel_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[sobel_pkg::WREG_W-1:0];
				sobel_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[HW-1:0];
				sobel_pkg::CFG_EDGE_SELECT:  sel_q    <= sobel_pkg::edge_sel_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// Clamp geometry to the supported range
	logic [CMPW-1:0] width_raw, width_eff;
	logic [HW-1:0]   height_eff;

	always_comb begin
		width_raw = CMPW'(width_q);
		if (width_raw < CMPW'(3))
			width_eff = CMPW'(3);
		else if (width_raw > CMPW'(MAX_WIDTH))
			width_eff = CMPW'(MAX_WIDTH);
		else
			width_eff = width_raw;
		if (height_q < sobel_pkg::HEIGHT_MIN)
			height_eff = sobel_pkg::HEIGHT_MIN;
		else if (height_q > sobel_pkg::HEIGHT_LIMIT)
			height_eff = sobel_pkg::HEIGHT_LIMIT;
		else
			height_eff = height_q;
	end

	// Pipeline handshake
	logic v_s1_q, v_s2_q, out_valid_q;
	logic emit_s1, emit_s2;
	logic adv_out, adv_s1, accept;

	assign adv_out  = !out_valid_q || !out_stall;
	assign adv_s1   = !v_s2_q || adv_out;
	assign in_stall = v_s1_q && !adv_s1;
	assign accept   = in_valid && !in_stall;

	// Raster position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          last_col, last_row, emit_now;

	always_comb begin
		last_col = (CMPW'(col_q) + CMPW'(1)) >= width_eff;
		last_row = (HW'(row_q) + HW'(1)) >= height_eff;
		emit_now = (row_q >= RW'(2)) && (col_q >= CW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : RW'(row_q + RW'(1));
			end else begin
				col_q <= CW'(col_q + CW'(1));
			end
		end
	end

	// Stage 1: line store read and pixel capture
	logic [CW-1:0] col_s1;
	logic [PW-1:0] pix_s1;
	logic          last_s1;
	logic [PW-1:0] upper_rd_s1, lower_rd_s1;
	logic          wr_en;

	assign wr_en = v_s1_q && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1_q <= 1'b0;
		else if (accept)
			v_s1_q <= 1'b1;
		else if (adv_s1)
			v_s1_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= col_q;
			pix_s1  <= pixel;
			emit_s1 <= emit_now;
			last_s1 <= last_col && last_row;
		end
	end

	// Line stores: read on input transfer, write back as the item leaves stage 1.
	// Consecutive pixels never share a column, so a read never overlaps a pending write.
	logic [PW-1:0] upper_mem [MAX_WIDTH];
	logic [PW-1:0] lower_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			upper_mem[col_s1] <= lower_rd_s1;
		if (accept)
			upper_rd_s1 <= upper_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			lower_mem[col_s1] <= pix_s1;
		if (accept)
			lower_rd_s1 <= lower_mem[col_q];
	end

	// Window: columns c-2 (win_q[0..2]) and c-1 (win_q[3..5]), top row first
	logic [PW-1:0] win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (wr_en) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= upper_rd_s1;
			win_q[4] <= lower_rd_s1;
			win_q[5] <= pix_s1;
		end
	end

	// Apply both masks
	logic signed [SW-1:0] vert_sum, horiz_sum;

	always_comb begin
		vert_sum  = (SW'(signed'({3'b0, upper_rd_s1})) - SW'(signed'({3'b0, win_q[0]})))
		          + ((SW'(signed'({3'b0, lower_rd_s1})) - SW'(signed'({3'b0, win_q[1]}))) <<< 1)
		          + (SW'(signed'({3'b0, pix_s1})) - SW'(signed'({3'b0, win_q[2]})));
		horiz_sum = (SW'(signed'({3'b0, win_q[0]})) + (SW'(signed'({3'b0, win_q[3]})) <<< 1)
		          + SW'(signed'({3'b0, upper_rd_s1})))
		          - (SW'(signed'({3'b0, win_q[2]})) + (SW'(signed'({3'b0, win_q[5]})) <<< 1)
		          + SW'(signed'({3'b0, pix_s1})));
	end

	// Stage 2: mask responses
	logic signed [SW-1:0] vert_s2, horiz_s2;
	logic                 last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2_q <= 1'b0;
		else if (adv_s1)
			v_s2_q <= v_s1_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vert_s2  <= vert_sum;
			horiz_s2 <= horiz_sum;
			emit_s2  <= emit_s1;
			last_s2  <= last_s1;
		end
	end

	// Magnitude select and saturate
	logic [SW-2:0] vert_abs, horiz_abs;
	logic [SW-1:0] mag_wide;
	logic [PW-1:0] mag_sat;

	always_comb begin
		vert_abs  = vert_s2[SW-1]  ? (SW-1)'(-vert_s2)  : vert_s2[SW-2:0];
		horiz_abs = horiz_s2[SW-1] ? (SW-1)'(-horiz_s2) : horiz_s2[SW-2:0];
		unique case (sel_q)
			sobel_pkg::SEL_VERT:  mag_wide = SW'(vert_abs);
			sobel_pkg::SEL_HORIZ: mag_wide = SW'(horiz_abs);
			sobel_pkg::SEL_SUM:   mag_wide = SW'(vert_abs) + SW'(horiz_abs);
			default:              mag_wide = '0;
		endcase
		mag_sat = (mag_wide > SW'(255)) ? PW'(255) : mag_wide[PW-1:0];
	end

	// Output register: border pixels drop out here
	logic [PW-1:0] mag_q;
	logic          last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_out)
			out_valid_q <= v_s2_q && emit_s2;
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2_q && emit_s2) begin
			mag_q  <= mag_sat;
			last_q <= last_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign magnitude  = mag_q;
	assign frame_last = last_q;

endmodule

// ===== hdl/sobel_chk.sv =====
module sobel_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [sobel_pkg::PIX_W-1:0] magnitude,
	input logic                        frame_last
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(magnitude) && $stable(frame_last))
		else $error("stalled result changed");

	// Input backpressure only comes from a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// Never stall the input while a result transfers
	a_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> !in_stall)
		else $error("input stalled while output accepts");

	// Reset empties the pipeline
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("pipeline not empty in reset");

endmodule

bind sobel_edge_3x3_top sobel_chk u_sobel_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.magnitude  (magnitude),
	.frame_last (frame_last)
);
